@@ sv/tlf_pkg.sv @@
// Shared types, constants and the control-store program for the text line folder.
// No dependencies; every other file of the block but tlf_ram imports this package.
`timescale 1ns / 1ps

package tlf_pkg;

    // Field widths.
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 7;
    localparam int LIM_W      = 7;
    localparam int TAB_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int UPC_W      = 5;

    // Upper bound on the column limit, keeping one item's output run short.
    localparam int FOLD_CAP = 40;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_BLANK   = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CH_HYPHEN  = 8'd45;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH  = 2'd1;
    localparam logic [LIM_W-1:0]     LIMIT_RESET    = 7'd40;
    localparam logic [TAB_W-1:0]     TAB_RESET      = 5'd4;

    typedef logic [UPC_W-1:0] upc_t;

    // Control-store addresses.
    localparam upc_t UPC_IDLE        = 5'd0;
    localparam upc_t UPC_SP_TEST     = 5'd1;
    localparam upc_t UPC_SP_BREAK    = 5'd2;
    localparam upc_t UPC_SP_WORD     = 5'd3;
    localparam upc_t UPC_SP_STREAM   = 5'd4;
    localparam upc_t UPC_SP_TEST_WS  = 5'd5;
    localparam upc_t UPC_SP_BREAK_WS = 5'd6;
    localparam upc_t UPC_SP_SEP      = 5'd7;
    localparam upc_t UPC_NL_TEST     = 5'd8;
    localparam upc_t UPC_NL_BREAK    = 5'd9;
    localparam upc_t UPC_NL_WORD     = 5'd10;
    localparam upc_t UPC_NL_STREAM   = 5'd11;
    localparam upc_t UPC_NL_END      = 5'd12;
    localparam upc_t UPC_OV_START    = 5'd13;
    localparam upc_t UPC_OV_STREAM   = 5'd14;
    localparam upc_t UPC_OV_HYPHEN   = 5'd15;
    localparam upc_t UPC_OV_END      = 5'd16;
    localparam upc_t UPC_ORD_STORE   = 5'd17;

    // Source of the byte sent out by a step.
    typedef enum logic [2:0] {
        EM_NONE,
        EM_NL,
        EM_HYPHEN,
        EM_CHAR,
        EM_MEM
    } emit_t;

    // Line column count update.
    typedef enum logic [1:0] {
        LC_KEEP,
        LC_ZERO,
        LC_ADD_WC,
        LC_ADD_WS
    } lc_op_t;

    // Word length update.
    typedef enum logic [1:0] {
        WC_KEEP,
        WC_ZERO,
        WC_ONE,
        WC_INC
    } wc_op_t;

    // Stream index update.
    typedef enum logic [1:0] {
        IX_KEEP,
        IX_ZERO,
        IX_INC
    } idx_op_t;

    // Word store read address.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_ZERO,
        RD_LIM1,
        RD_NEXT
    } rd_sel_t;

    // Word store write: new byte at the tail, or carried byte at the head.
    typedef enum logic [1:0] {
        WR_NONE,
        WR_TAIL,
        WR_HEAD
    } wr_sel_t;

    // End of a streaming loop: the word length, or the limit minus one.
    typedef enum logic {
        END_WC,
        END_LIM1
    } end_sel_t;

    // Jump condition.
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_DISPATCH,
        JC_WORD_FITS,
        JC_WC_ZERO,
        JC_WS_FITS,
        JC_MORE
    } jcond_t;

    // One control word.
    typedef struct packed {
        logic     accept;
        emit_t    emit;
        logic     last;
        lc_op_t   lc_op;
        wc_op_t   wc_op;
        idx_op_t  idx_op;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        end_sel_t end_sel;
        jcond_t   cond;
        upc_t     target;
    } uword_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic advance;
        logic is_sep;
        logic is_nl;
        logic wc_full;
        logic word_fits;
        logic wc_zero;
        logic ws_fits;
        logic more;
    } uflags_t;

    localparam uword_t UWORD_NOP = '{
        accept:  1'b0,
        emit:    EM_NONE,
        last:    1'b0,
        lc_op:   LC_KEEP,
        wc_op:   WC_KEEP,
        idx_op:  IX_KEEP,
        rd_sel:  RD_NONE,
        wr_sel:  WR_NONE,
        end_sel: END_WC,
        cond:    JC_NEXT,
        target:  UPC_IDLE
    };

    // The control store. A conditional jump goes to target when the
    // condition holds and falls through to the next step otherwise.
    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        w = UWORD_NOP;
        unique case (pc)
            UPC_IDLE:
            begin
                w.accept = 1'b1;
                w.cond   = JC_DISPATCH;
            end
            // Blank or tab: word, then the separator, each on a new line if needed.
            UPC_SP_TEST:
            begin
                w.cond   = JC_WORD_FITS;
                w.target = UPC_SP_WORD;
            end
            UPC_SP_BREAK:
            begin
                w.emit  = EM_NL;
                w.lc_op = LC_ZERO;
            end
            UPC_SP_WORD:
            begin
                w.lc_op  = LC_ADD_WC;
                w.idx_op = IX_ZERO;
                w.rd_sel = RD_ZERO;
                w.cond   = JC_WC_ZERO;
                w.target = UPC_SP_TEST_WS;
            end
            UPC_SP_STREAM:
            begin
                w.emit    = EM_MEM;
                w.idx_op  = IX_INC;
                w.rd_sel  = RD_NEXT;
                w.end_sel = END_WC;
                w.cond    = JC_MORE;
                w.target  = UPC_SP_STREAM;
            end
            UPC_SP_TEST_WS:
            begin
                w.cond   = JC_WS_FITS;
                w.target = UPC_SP_SEP;
            end
            UPC_SP_BREAK_WS:
            begin
                w.emit  = EM_NL;
                w.lc_op = LC_ZERO;
            end
            UPC_SP_SEP:
            begin
                w.emit   = EM_CHAR;
                w.last   = 1'b1;
                w.lc_op  = LC_ADD_WS;
                w.wc_op  = WC_ZERO;
                w.cond   = JC_ALWAYS;
                w.target = UPC_IDLE;
            end
            // Newline: word, then the newline; counts start over.
            UPC_NL_TEST:
            begin
                w.cond   = JC_WORD_FITS;
                w.target = UPC_NL_WORD;
            end
            UPC_NL_BREAK:
            begin
                w.emit = EM_NL;
            end
            UPC_NL_WORD:
            begin
                w.idx_op = IX_ZERO;
                w.rd_sel = RD_ZERO;
                w.cond   = JC_WC_ZERO;
                w.target = UPC_NL_END;
            end
            UPC_NL_STREAM:
            begin
                w.emit    = EM_MEM;
                w.idx_op  = IX_INC;
                w.rd_sel  = RD_NEXT;
                w.end_sel = END_WC;
                w.cond    = JC_MORE;
                w.target  = UPC_NL_STREAM;
            end
            UPC_NL_END:
            begin
                w.emit   = EM_NL;
                w.last   = 1'b1;
                w.lc_op  = LC_ZERO;
                w.wc_op  = WC_ZERO;
                w.cond   = JC_ALWAYS;
                w.target = UPC_IDLE;
            end
            // Full word: split it with a hyphen, carry the last byte over.
            UPC_OV_START:
            begin
                w.idx_op = IX_ZERO;
                w.rd_sel = RD_ZERO;
            end
            UPC_OV_STREAM:
            begin
                w.emit    = EM_MEM;
                w.idx_op  = IX_INC;
                w.rd_sel  = RD_NEXT;
                w.end_sel = END_LIM1;
                w.cond    = JC_MORE;
                w.target  = UPC_OV_STREAM;
            end
            UPC_OV_HYPHEN:
            begin
                w.emit   = EM_HYPHEN;
                w.rd_sel = RD_LIM1;
            end
            UPC_OV_END:
            begin
                w.emit   = EM_NL;
                w.last   = 1'b1;
                w.wr_sel = WR_HEAD;
                w.wc_op  = WC_ONE;
                w.lc_op  = LC_ZERO;
                w.cond   = JC_ALWAYS;
                w.target = UPC_ORD_STORE;
            end
            // Ordinary byte: append to the word.
            UPC_ORD_STORE:
            begin
                w.wr_sel = WR_TAIL;
                w.wc_op  = WC_INC;
                w.cond   = JC_ALWAYS;
                w.target = UPC_IDLE;
            end
            default:
            begin
                w.cond   = JC_ALWAYS;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ sv/tlf_raw_if.sv @@
// Input channel of the text line folder: one text byte per item.
// Depends on tlf_pkg for the byte width.
`timescale 1ns / 1ps

interface tlf_raw_if import tlf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
    modport mon    (input valid, input ready, input in_byte);
endinterface

@@ sv/tlf_folded_if.sv @@
// Output channel of the text line folder: one folded text byte per item.
// Depends on tlf_pkg for the byte width.
`timescale 1ns / 1ps

interface tlf_folded_if import tlf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
    modport mon    (input valid, input ready, input out_byte, input last_of_run);
endinterface

@@ sv/tlf_cfg_if.sv @@
// Configuration write channel of the text line folder: register index and data.
// Depends on tlf_pkg for the index and data widths.
`timescale 1ns / 1ps

interface tlf_cfg_if import tlf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
    modport mon    (input valid, input ready, input index, input data);
endinterface

@@ sv/tlf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/tlf_seq.sv @@
// Microcode sequencer of the text line folder: step counter, control store, jumps.
// Depends on tlf_pkg for the control word, status flags and program.
`timescale 1ns / 1ps

module tlf_seq import tlf_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  uflags_t flags,
    output uword_t  ctrl
);

    upc_t pc_reg;
    upc_t pc_next;
    upc_t pc_inc;
    upc_t dispatch_target;

    assign ctrl   = ucode(pc_reg);
    assign pc_inc = upc_t'(pc_reg + upc_t'(1));

    // Entry point for a newly accepted byte, by its class.
    always_comb
    begin
        priority if (flags.is_sep)
        begin
            dispatch_target = UPC_SP_TEST;
        end
        else if (flags.is_nl)
        begin
            dispatch_target = UPC_NL_TEST;
        end
        else if (flags.wc_full)
        begin
            dispatch_target = UPC_OV_START;
        end
        else
        begin
            dispatch_target = UPC_ORD_STORE;
        end
    end

    // Next step; a step that cannot finish this cycle is repeated.
    always_comb
    begin
        pc_next = pc_reg;
        if (flags.advance)
        begin
            unique case (ctrl.cond)
                JC_NEXT:      pc_next = pc_inc;
                JC_ALWAYS:    pc_next = ctrl.target;
                JC_DISPATCH:  pc_next = dispatch_target;
                JC_WORD_FITS: pc_next = flags.word_fits ? ctrl.target : pc_inc;
                JC_WC_ZERO:   pc_next = flags.wc_zero ? ctrl.target : pc_inc;
                JC_WS_FITS:   pc_next = flags.ws_fits ? ctrl.target : pc_inc;
                JC_MORE:      pc_next = flags.more ? ctrl.target : pc_inc;
                default:      pc_next = UPC_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= UPC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ sv/tlf_dpath.sv @@
// Datapath of the text line folder: counts, word store, output register, config.
// Depends on tlf_pkg, the three channel interfaces and tlf_ram.
`timescale 1ns / 1ps

module tlf_dpath import tlf_pkg::*; #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  uword_t          ctrl,
    output uflags_t         flags,
    tlf_raw_if.sink         raw,
    tlf_folded_if.source    folded,
    tlf_cfg_if.sink         cfg
);

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int CAP_INT = (BUFFER_DEPTH < FOLD_CAP) ? BUFFER_DEPTH : FOLD_CAP;
    localparam logic [LIM_W-1:0] LIM_CAP = LIM_W'(CAP_INT);
    localparam logic [LIM_W-1:0] LIM_MIN = LIM_W'(2);

    logic [LIM_W-1:0]  line_limit_reg;
    logic [TAB_W-1:0]  tab_width_reg;
    logic [CNT_W-1:0]  wc_reg;
    logic [CNT_W-1:0]  wc_next;
    logic [CNT_W-1:0]  lc_reg;
    logic [CNT_W-1:0]  lc_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic [CNT_W-1:0]  idx_inc;
    logic [BYTE_W-1:0] byte_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic [LIM_W-1:0]  lim;
    logic [LIM_W-1:0]  lim_m1;
    logic [LIM_W-1:0]  cfg_lim;
    logic [TAB_W-1:0]  ws;
    logic [CNT_W:0]    word_sum;
    logic [CNT_W:0]    ws_sum;
    logic [CNT_W-1:0]  end_val;
    logic              can_load;
    logic              advance;
    logic              load;
    logic [BYTE_W-1:0] emit_byte;
    logic              limit_wr;
    logic              tab_wr;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [BYTE_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;

    // Column limit clamped to the supported range.
    function automatic logic [LIM_W-1:0] eff_limit(input logic [LIM_W-1:0] v);
        logic [LIM_W-1:0] r;
        if (v < LIM_MIN)
        begin
            r = LIM_MIN;
        end
        else if (v > LIM_CAP)
        begin
            r = LIM_CAP;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign lim     = eff_limit(line_limit_reg);
    assign lim_m1  = lim - LIM_W'(1);
    assign cfg_lim = eff_limit(cfg.data[LIM_W-1:0]);

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;
    assign limit_wr  = cfg.valid && (cfg.index == REG_LINE_LIMIT);
    assign tab_wr    = cfg.valid && (cfg.index == REG_TAB_WIDTH);

    // An accept step ends on input; others when their byte (if any) can load.
    assign can_load  = !out_valid_reg || folded.ready;
    assign raw.ready = ctrl.accept;
    always_comb
    begin
        if (ctrl.accept)
        begin
            advance = raw.valid;
        end
        else if (ctrl.emit != EM_NONE)
        begin
            advance = can_load;
        end
        else
        begin
            advance = 1'b1;
        end
    end
    assign load = advance && (ctrl.emit != EM_NONE);

    // Column tests.
    assign ws       = (byte_reg == CH_TAB) ? tab_width_reg : TAB_W'(1);
    assign word_sum = {1'b0, lc_reg} + {1'b0, wc_reg};
    assign ws_sum   = {1'b0, lc_reg} + (CNT_W+1)'(ws);
    assign end_val  = (ctrl.end_sel == END_LIM1) ? lim_m1 : wc_reg;
    assign idx_inc  = idx_reg + CNT_W'(1);

    always_comb
    begin
        flags.advance   = advance;
        flags.is_sep    = (raw.in_byte == CH_BLANK) || (raw.in_byte == CH_TAB);
        flags.is_nl     = (raw.in_byte == CH_NEWLINE);
        flags.wc_full   = (wc_reg >= lim);
        flags.word_fits = (word_sum <= {1'b0, lim});
        flags.wc_zero   = (wc_reg == '0);
        flags.ws_fits   = (ws_sum <= {1'b0, lim});
        flags.more      = (idx_inc < end_val);
    end

    // Byte sent out by the current step.
    always_comb
    begin
        unique case (ctrl.emit)
            EM_NL:     emit_byte = CH_NEWLINE;
            EM_HYPHEN: emit_byte = CH_HYPHEN;
            EM_CHAR:   emit_byte = byte_reg;
            EM_MEM:    emit_byte = ram_rd_data;
            default:   emit_byte = '0;
        endcase
    end

    // Word store access.
    always_comb
    begin
        ram_wr_en   = advance && (ctrl.wr_sel != WR_NONE);
        ram_wr_addr = (ctrl.wr_sel == WR_HEAD) ? '0 : AW'(wc_reg);
        ram_wr_data = (ctrl.wr_sel == WR_HEAD) ? ram_rd_data : byte_reg;
        ram_rd_en   = (ctrl.rd_sel != RD_NONE);
        unique case (ctrl.rd_sel)
            RD_ZERO: ram_rd_addr = '0;
            RD_LIM1: ram_rd_addr = AW'(lim_m1);
            RD_NEXT: ram_rd_addr = advance ? AW'(idx_inc) : AW'(idx_reg);
            default: ram_rd_addr = AW'(idx_reg);
        endcase
    end

    tlf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_word_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Counter updates.
    always_comb
    begin
        lc_next  = lc_reg;
        wc_next  = wc_reg;
        idx_next = idx_reg;
        if (advance)
        begin
            unique case (ctrl.lc_op)
                LC_ZERO:   lc_next = '0;
                LC_ADD_WC: lc_next = word_sum[CNT_W-1:0];
                LC_ADD_WS: lc_next = ws_sum[CNT_W-1:0];
                default:   lc_next = lc_reg;
            endcase
            unique case (ctrl.wc_op)
                WC_ZERO: wc_next = '0;
                WC_ONE:  wc_next = CNT_W'(1);
                WC_INC:  wc_next = wc_reg + CNT_W'(1);
                default: wc_next = wc_reg;
            endcase
            unique case (ctrl.idx_op)
                IX_ZERO: idx_next = '0;
                IX_INC:  idx_next = idx_inc;
                default: idx_next = idx_reg;
            endcase
        end
        // A lowered limit cuts a longer pending word.
        if (limit_wr && (wc_reg > cfg_lim))
        begin
            wc_next = cfg_lim;
        end
    end

    // Output register handshake.
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (folded.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= LIMIT_RESET;
            tab_width_reg  <= TAB_RESET;
            wc_reg         <= '0;
            lc_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (limit_wr)
            begin
                line_limit_reg <= cfg.data[LIM_W-1:0];
            end
            if (tab_wr)
            begin
                tab_width_reg <= cfg.data[TAB_W-1:0];
            end
            wc_reg        <= wc_next;
            lc_reg        <= lc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctrl.accept && raw.valid)
        begin
            byte_reg <= raw.in_byte;
        end
        if (load)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= ctrl.last;
        end
    end

    assign folded.valid       = out_valid_reg;
    assign folded.out_byte    = out_byte_reg;
    assign folded.last_of_run = out_last_reg;

endmodule

@@ sv/text_line_folder_core.sv @@
// Top level of the text line folder: greedy word wrap of a byte stream.
// Depends on tlf_pkg, the channel interfaces, tlf_seq and tlf_dpath.
//
//   Channel   Dir   Payload                     Item
//   raw       in    in_byte[7:0]                one input text byte
//   folded    out   out_byte[7:0], last_of_run  one folded text byte
//   cfg       in    index[1:0], data[6:0]       one register write
//
// An ordinary byte is stored; a blank, tab or newline sends the word and then
// itself, after a newline where either does not fit; a full word sends all but
// its last byte, a hyphen and a newline, and carries the last byte over. One
// control step runs per cycle and at most one byte per cycle leaves through a
// single output register, so a step that sends a byte waits while folded is
// stalled. Reset clears the word and line counts and the output valid flag.
`timescale 1ns / 1ps

module text_line_folder_core import tlf_pkg::*; #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    tlf_raw_if.sink      raw,
    tlf_folded_if.source folded,
    tlf_cfg_if.sink      cfg
);

    uword_t  ctrl;
    uflags_t flags;

    // Control sequencer.
    tlf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Datapath with the word store.
    tlf_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .flags  (flags),
        .raw    (raw),
        .folded (folded),
        .cfg    (cfg)
    );

endmodule

@@ sv/tlf_chk.sv @@
// Port-level checker for the text line folder, bound to the top level.
// Depends on tlf_pkg and the channel interfaces.
`timescale 1ns / 1ps

module tlf_chk import tlf_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    tlf_raw_if.sink      raw,
    tlf_folded_if.source folded,
    tlf_cfg_if.sink      cfg
);

    // A stalled output item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        folded.valid && !folded.ready |=>
            folded.valid && $stable(folded.out_byte) && $stable(folded.last_of_run))
        else $error("folded item changed while stalled");

    // Accepting a byte starts its processing; no second byte next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        raw.valid && raw.ready |=> !raw.ready)
        else $error("input accepted twice in a row");

    // Every run ends on a line break or a separator.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        folded.valid && folded.last_of_run |->
            (folded.out_byte == CH_NEWLINE) || (folded.out_byte == CH_BLANK)
            || (folded.out_byte == CH_TAB))
        else $error("run ended on an unexpected byte");

    // While waiting for input, only a finished run's last item may be pending.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        raw.ready |-> !folded.valid || folded.last_of_run)
        else $error("input taken in the middle of a run");

    // Register writes are never held off.
    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |-> cfg.ready)
        else $error("register write stalled");

endmodule

bind text_line_folder_core tlf_chk u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .raw    (raw),
    .folded (folded),
    .cfg    (cfg)
);
